// ===== rtl/gta_pkg.sv =====
package gta_pkg;

  localparam int unsigned MAX_TRACKS_DEF  = 64;
  localparam int unsigned COORD_BITS_DEF  = 24;
  localparam int unsigned GATE_BITS       = 23;
  localparam int unsigned CLASS_BITS      = 8;
  localparam int unsigned INDEX_BITS      = 6;
  localparam logic [GATE_BITS-1:0] GATE_RESET = 23'd1280;

  // per-cell control of the track ring
  typedef struct packed {
    logic shift;      // take the neighbor's record
    logic load;       // write the committed record
    logic clr_match;  // new frame starts
  } cell_ctrl_t;

endpackage

// ===== rtl/gta_cell.sv =====
module gta_cell #(
  parameter int unsigned COORD_BITS = gta_pkg::COORD_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  gta_pkg::cell_ctrl_t             ctrl_i,
  input  logic [COORD_BITS-1:0]           nxt_x_i,
  input  logic [COORD_BITS-1:0]           nxt_y_i,
  input  logic [gta_pkg::CLASS_BITS-1:0]  nxt_class_i,
  input  logic                            nxt_match_i,
  input  logic [COORD_BITS-1:0]           wr_x_i,
  input  logic [COORD_BITS-1:0]           wr_y_i,
  input  logic [gta_pkg::CLASS_BITS-1:0]  wr_class_i,
  input  logic                            wr_match_i,
  output logic [COORD_BITS-1:0]           x_o,
  output logic [COORD_BITS-1:0]           y_o,
  output logic [gta_pkg::CLASS_BITS-1:0]  class_o,
  output logic                            match_o
);

  logic [COORD_BITS-1:0]          x_q, y_q;
  logic [gta_pkg::CLASS_BITS-1:0] class_q;
  logic                           match_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else if (ctrl_i.clr_match) begin
      match_q <= 1'b0;
    end else if (ctrl_i.load) begin
      match_q <= wr_match_i;
    end else if (ctrl_i.shift) begin
      match_q <= nxt_match_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      x_q     <= wr_x_i;
      y_q     <= wr_y_i;
      class_q <= wr_class_i;
    end else if (ctrl_i.shift) begin
      x_q     <= nxt_x_i;
      y_q     <= nxt_y_i;
      class_q <= nxt_class_i;
    end
  end

  assign x_o     = x_q;
  assign y_o     = y_q;
  assign class_o = class_q;
  assign match_o = match_q;

endmodule

// ===== rtl/gta_eval.sv =====
module gta_eval #(
  parameter int unsigned COORD_BITS = gta_pkg::COORD_BITS_DEF,
  parameter int unsigned IDX_W      = gta_pkg::INDEX_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic                              issue_i,
  input  logic [IDX_W-1:0]                  idx_i,
  input  logic [COORD_BITS-1:0]             trk_x_i,
  input  logic [COORD_BITS-1:0]             trk_y_i,
  input  logic [gta_pkg::CLASS_BITS-1:0]    trk_class_i,
  input  logic                              trk_match_i,
  input  logic [COORD_BITS-1:0]             det_x_i,
  input  logic [COORD_BITS-1:0]             det_y_i,
  input  logic [gta_pkg::CLASS_BITS-1:0]    det_class_i,
  input  logic [gta_pkg::GATE_BITS-1:0]     gate_i,
  input  logic [2*gta_pkg::GATE_BITS-1:0]   gate_sq_i,
  output logic                              busy_o,
  output logic                              found_o,
  output logic [IDX_W-1:0]                  found_idx_o,
  output logic [COORD_BITS-1:0]             avg_x_o,
  output logic [COORD_BITS-1:0]             avg_y_o
);

  localparam int unsigned GB = gta_pkg::GATE_BITS;
  localparam int unsigned DW = (COORD_BITS + 1 > GB) ? COORD_BITS + 1 : GB;

  // stage a: class and flag check, absolute differences, midpoint
  logic signed [COORD_BITS:0] diff_x, diff_y, sum_x, sum_y;
  logic [COORD_BITS:0]        abs_x, abs_y;
  logic                       ok_a;

  logic                  va_q, vb_q;
  logic [IDX_W-1:0]      idx_a_q, idx_b_q;
  logic [COORD_BITS:0]   dx_a_q, dy_a_q;
  logic [COORD_BITS-1:0] mx_a_q, my_a_q, mx_b_q, my_b_q;
  logic [2*GB-1:0]       sqx_b_q, sqy_b_q;

  logic [DW-1:0] dx_ext, dy_ext, gate_ext;
  logic          near;
  logic [2*GB:0] dist_sq;

  logic                  found_q;
  logic [IDX_W-1:0]      found_idx_q;
  logic [COORD_BITS-1:0] avg_x_q, avg_y_q;

  always_comb begin
    diff_x = $signed({det_x_i[COORD_BITS-1], det_x_i}) - $signed({trk_x_i[COORD_BITS-1], trk_x_i});
    diff_y = $signed({det_y_i[COORD_BITS-1], det_y_i}) - $signed({trk_y_i[COORD_BITS-1], trk_y_i});
    abs_x  = diff_x[COORD_BITS] ? $unsigned(-diff_x) : $unsigned(diff_x);
    abs_y  = diff_y[COORD_BITS] ? $unsigned(-diff_y) : $unsigned(diff_y);
    sum_x  = $signed({det_x_i[COORD_BITS-1], det_x_i}) + $signed({trk_x_i[COORD_BITS-1], trk_x_i});
    sum_y  = $signed({det_y_i[COORD_BITS-1], det_y_i}) + $signed({trk_y_i[COORD_BITS-1], trk_y_i});
    ok_a   = issue_i && !trk_match_i && (trk_class_i == det_class_i);
  end

  // stage b: per-axis gate and squares
  always_comb begin
    dx_ext   = DW'(dx_a_q);
    dy_ext   = DW'(dy_a_q);
    gate_ext = DW'(gate_i);
    near     = (dx_ext < gate_ext) && (dy_ext < gate_ext);
  end

  // stage c: radial gate
  assign dist_sq = {1'b0, sqx_b_q} + {1'b0, sqy_b_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q    <= 1'b0;
      vb_q    <= 1'b0;
      found_q <= 1'b0;
    end else begin
      va_q <= ok_a;
      vb_q <= va_q && near;
      if (start_i) begin
        found_q <= 1'b0;
      end else if (vb_q && !found_q && (dist_sq < {1'b0, gate_sq_i})) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_a_q <= idx_i;
    dx_a_q  <= abs_x;
    dy_a_q  <= abs_y;
    mx_a_q  <= sum_x[COORD_BITS:1];
    my_a_q  <= sum_y[COORD_BITS:1];
    idx_b_q <= idx_a_q;
    mx_b_q  <= mx_a_q;
    my_b_q  <= my_a_q;
    sqx_b_q <= dx_ext[GB-1:0] * dx_ext[GB-1:0];
    sqy_b_q <= dy_ext[GB-1:0] * dy_ext[GB-1:0];
    if (!start_i && vb_q && !found_q && (dist_sq < {1'b0, gate_sq_i})) begin
      found_idx_q <= idx_b_q;
      avg_x_q     <= mx_b_q;
      avg_y_q     <= my_b_q;
    end
  end

  assign busy_o      = va_q || vb_q;
  assign found_o     = found_q;
  assign found_idx_o = found_idx_q;
  assign avg_x_o     = avg_x_q;
  assign avg_y_o     = avg_y_q;

endmodule

// ===== rtl/gated_track_association_top.sv =====
// channel   | direction | handshake                   | payload
// ----------+-----------+-----------------------------+----------------------------------------
// detection | in        | in_valid_i / in_stall_o     | det_x_i det_y_i det_class_i frame_first_i
// result    | out       | out_valid_o / out_stall_i   | was_matched_o track_index_o new_x_o
//           |           |                             | new_y_o table_full_o
// gate cfg  | in        | cfg_valid_i / cfg_ready_o   | cfg_data_i (gate_distance)
//
// the track ring rotates once past the shared three-stage distance unit, the pipe drains until
// the unit is no longer busy and the result is committed: out_valid_o rises when the commit
// finds the output register free.
// a new detection is taken only in idle, from the cycle after the commit; the finished result
// sits in the output register, so the next detection may enter while it is still stalled.
// reset clears the track count, the frame start count and all matched flags.
module gated_track_association_top #(
  parameter int unsigned MAX_TRACKS = gta_pkg::MAX_TRACKS_DEF,
  parameter int unsigned COORD_BITS = gta_pkg::COORD_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [COORD_BITS-1:0]     det_x_i,
  input  logic signed [COORD_BITS-1:0]     det_y_i,
  input  logic [gta_pkg::CLASS_BITS-1:0]   det_class_i,
  input  logic                             frame_first_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             was_matched_o,
  output logic [gta_pkg::INDEX_BITS-1:0]   track_index_o,
  output logic signed [COORD_BITS-1:0]     new_x_o,
  output logic signed [COORD_BITS-1:0]     new_y_o,
  output logic                             table_full_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [gta_pkg::GATE_BITS-1:0]    cfg_data_i
);

  localparam int unsigned IDX_W = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_TRACKS + 1);
  localparam int unsigned GB    = gta_pkg::GATE_BITS;
  localparam int unsigned IB    = gta_pkg::INDEX_BITS;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } state_e;

  state_e                         state_q;
  logic [CNT_W-1:0]               step_q, count_q, fsc_q;
  logic [GB-1:0]                  gate_q;
  logic [2*GB-1:0]                gate_sq_q;
  logic [COORD_BITS-1:0]          det_x_q, det_y_q;
  logic [gta_pkg::CLASS_BITS-1:0] det_class_q;

  logic                  out_valid_q, was_matched_q, table_full_q;
  logic [IB-1:0]         track_index_q;
  logic [COORD_BITS-1:0] new_x_q, new_y_q;

  logic                  accept, scanning, out_free, commit_go, tbl_full, commit_wr;
  logic [IDX_W-1:0]      wr_idx;
  logic [COORD_BITS-1:0] wr_x, wr_y;
  logic [IDX_W+IB-1:0]   idx_ext;

  logic                  busy, found;
  logic [IDX_W-1:0]      found_idx;
  logic [COORD_BITS-1:0] avg_x, avg_y;

  logic [COORD_BITS-1:0]          cell_x     [MAX_TRACKS];
  logic [COORD_BITS-1:0]          cell_y     [MAX_TRACKS];
  logic [gta_pkg::CLASS_BITS-1:0] cell_class [MAX_TRACKS];
  logic                           cell_match [MAX_TRACKS];

  assign accept   = (state_q == ST_IDLE) && in_valid_i;
  assign scanning = (state_q == ST_SCAN);
  assign out_free = !out_valid_q || !out_stall_i;
  assign commit_go = (state_q == ST_COMMIT) && out_free;
  assign tbl_full  = (count_q == CNT_W'(MAX_TRACKS));
  assign commit_wr = commit_go && (found || !tbl_full);
  assign wr_idx    = found ? found_idx : count_q[IDX_W-1:0];
  assign wr_x      = found ? avg_x : det_x_q;
  assign wr_y      = found ? avg_y : det_y_q;
  assign idx_ext   = {{IB{1'b0}}, wr_idx};

  // track ring: cell 0 is the head seen by the distance unit
  for (genvar i = 0; i < MAX_TRACKS; i++) begin : g_ring
    gta_pkg::cell_ctrl_t ctrl;
    always_comb begin
      ctrl.shift     = scanning;
      ctrl.load      = commit_wr && (wr_idx == IDX_W'(i));
      ctrl.clr_match = accept && frame_first_i;
    end
    gta_cell #(
      .COORD_BITS(COORD_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .nxt_x_i    (cell_x[(i + 1) % MAX_TRACKS]),
      .nxt_y_i    (cell_y[(i + 1) % MAX_TRACKS]),
      .nxt_class_i(cell_class[(i + 1) % MAX_TRACKS]),
      .nxt_match_i(cell_match[(i + 1) % MAX_TRACKS]),
      .wr_x_i     (wr_x),
      .wr_y_i     (wr_y),
      .wr_class_i (det_class_q),
      .wr_match_i (found),
      .x_o        (cell_x[i]),
      .y_o        (cell_y[i]),
      .class_o    (cell_class[i]),
      .match_o    (cell_match[i])
    );
  end

  gta_eval #(
    .COORD_BITS(COORD_BITS),
    .IDX_W     (IDX_W)
  ) u_eval (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .issue_i    (scanning && (step_q < fsc_q)),
    .idx_i      (step_q[IDX_W-1:0]),
    .trk_x_i    (cell_x[0]),
    .trk_y_i    (cell_y[0]),
    .trk_class_i(cell_class[0]),
    .trk_match_i(cell_match[0]),
    .det_x_i    (det_x_q),
    .det_y_i    (det_y_q),
    .det_class_i(det_class_q),
    .gate_i     (gate_q),
    .gate_sq_i  (gate_sq_q),
    .busy_o     (busy),
    .found_o    (found),
    .found_idx_o(found_idx),
    .avg_x_o    (avg_x),
    .avg_y_o    (avg_y)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      step_q        <= '0;
      count_q       <= '0;
      fsc_q         <= '0;
      gate_q        <= gta_pkg::GATE_RESET;
      out_valid_q   <= 1'b0;
      was_matched_q <= 1'b0;
      table_full_q  <= 1'b0;
      track_index_q <= '0;
      new_x_q       <= '0;
      new_y_q       <= '0;
    end else begin
      if (cfg_valid_i) begin
        gate_q <= cfg_data_i;
      end
      if (out_valid_q && !out_stall_i && !commit_go) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            step_q  <= '0;
            state_q <= ST_SCAN;
            if (frame_first_i) begin
              fsc_q <= count_q;
            end
          end
        end
        ST_SCAN: begin
          step_q <= step_q + CNT_W'(1);
          if (step_q == CNT_W'(MAX_TRACKS - 1)) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!busy) begin
            state_q <= ST_COMMIT;
          end
        end
        ST_COMMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
            if (found) begin
              was_matched_q <= 1'b1;
              table_full_q  <= 1'b0;
              track_index_q <= idx_ext[IB-1:0];
              new_x_q       <= avg_x;
              new_y_q       <= avg_y;
            end else if (tbl_full) begin
              was_matched_q <= 1'b0;
              table_full_q  <= 1'b1;
              track_index_q <= '0;
              new_x_q       <= '0;
              new_y_q       <= '0;
            end else begin
              was_matched_q <= 1'b0;
              table_full_q  <= 1'b0;
              track_index_q <= idx_ext[IB-1:0];
              new_x_q       <= det_x_q;
              new_y_q       <= det_y_q;
              count_q       <= count_q + CNT_W'(1);
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    gate_sq_q <= gate_q * gate_q;
    if (accept) begin
      det_x_q     <= det_x_i;
      det_y_q     <= det_y_i;
      det_class_q <= det_class_i;
    end
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign out_valid_o   = out_valid_q;
  assign was_matched_o = was_matched_q;
  assign track_index_o = track_index_q;
  assign new_x_o       = new_x_q;
  assign new_y_o       = new_y_q;
  assign table_full_o  = table_full_q;

endmodule
